// ----- src/two_point_channel_calibrator_defines.svh -----
// Assertion macros for the two-point channel calibrator
`ifndef TWO_POINT_CHANNEL_CALIBRATOR_DEFINES_SVH
`define TWO_POINT_CHANNEL_CALIBRATOR_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define TPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/tpc_pkg.sv -----
// Package: types and constants of the two-point channel calibrator
`timescale 1ns / 1ps
package tpc_pkg;
  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_APPEND  = 2'd1;
  localparam logic [1:0] ACT_MEASURE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_CAL   = 2'd1;
  localparam logic [1:0] ST_PASS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SLP, S_OFS, S_SCAN, S_MUL, S_OUT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ----- src/two_point_channel_calibrator.sv -----
// Top level: two-point channel calibration table
// Usage: pulse start with an item while busy is low. action 0 clears the
// table, 1 appends a calibration from two point pairs, 2 calibrates
// raw_value with the last matching entry. One result per item appears on
// out_* for one cycle with out_valid high; the receiver cannot stall.
// Sequence: clear, append to a full table and unused actions go straight
// to the result cycle; append runs a radix-2 restoring divider that yields
// one quotient bit per cycle over 50 bits, then slope saturation, the
// offset multiply and the offset update; measure scans the table memory
// at one entry per cycle over its single read port, then multiplies.
// busy is high from the accepting edge until the result cycle ends.
// Reset (synchronous, rst_n low) empties the table; memory contents stay
// undefined and are never read beyond the fill count.
`timescale 1ns / 1ps
module two_point_channel_calibrator #(
  parameter int TABLE_DEPTH = 128,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [15:0]        in_channel_id,
  input  logic signed [31:0] in_raw_value,
  input  logic signed [31:0] in_point1_raw,
  input  logic signed [31:0] in_point1_cal,
  input  logic signed [31:0] in_point2_raw,
  input  logic signed [31:0] in_point2_cal,
  output logic               out_valid,
  output logic signed [31:0] out_value_out,
  output logic [1:0]         out_status,
  output logic [7:0]         out_entries_used
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = 34 + FRAC_BITS;

  tpc_pkg::state_t state_r, state_nxt;

  // entry layout: channel, slope, offset
  logic [79:0]  mem_ent [TABLE_DEPTH];
  logic [79:0]  rd_ent_r;
  logic [15:0]  rd_chan;
  logic [31:0]  rd_slope, rd_ofs;

  logic [CW-1:0] count_r;
  logic [1:0]    act_r;
  logic [15:0]   chan_r;
  logic signed [31:0] raw_r, r1_r, c1_r;
  logic [CW-1:0] idx_r;
  logic          rd_vld_r;
  logic          hit_r;
  logic signed [31:0] a_r, b_r;
  logic [NW-1:0] rem_r, quo_r;
  logic [NW-1:0] dvs_r;
  logic [5:0]    bit_r;
  logic          neg_r;
  logic signed [63:0] prod_r;
  logic [1:0]    st_r;
  logic          wr_en;

  logic [NW:0]   rem_sh;
  logic signed [NW:0] q_s;
  logic signed [65:0] fl;
  logic signed [31:0] b_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpc_pkg::S_IDLE: if (start) begin
        priority if (in_action == tpc_pkg::ACT_APPEND && count_r != CW'(TABLE_DEPTH))
          state_nxt = tpc_pkg::S_DIV;
        else if (in_action == tpc_pkg::ACT_MEASURE) state_nxt = tpc_pkg::S_SCAN;
        else state_nxt = tpc_pkg::S_OUT;
      end
      tpc_pkg::S_DIV:  if (bit_r == 6'd0) state_nxt = tpc_pkg::S_SLP;
      tpc_pkg::S_SLP:  state_nxt = tpc_pkg::S_OFS;
      tpc_pkg::S_OFS:  state_nxt = tpc_pkg::S_MUL;
      tpc_pkg::S_SCAN: if (idx_r == count_r && !rd_vld_r) state_nxt = tpc_pkg::S_MUL;
      tpc_pkg::S_MUL:  state_nxt = tpc_pkg::S_OUT;
      tpc_pkg::S_OUT:  state_nxt = tpc_pkg::S_IDLE;
      default:         state_nxt = tpc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != tpc_pkg::S_IDLE);
    out_valid = (state_r == tpc_pkg::S_OUT);
    wr_en     = (state_r == tpc_pkg::S_MUL) && (act_r == tpc_pkg::ACT_APPEND);
  end

  assign rem_sh = {rem_r, quo_r[NW-1]};
  assign q_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign fl = $signed({{2{prod_r[63]}}, prod_r}) >>> FRAC_BITS;
  assign b_nxt = hit_r ? b_r : tpc_pkg::sat32(66'(c1_r) - fl);

  assign rd_chan  = rd_ent_r[79:64];
  assign rd_slope = rd_ent_r[63:32];
  assign rd_ofs   = rd_ent_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpc_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tpc_pkg::S_IDLE && start && in_action == tpc_pkg::ACT_CLEAR)
        count_r <= '0;
      if (wr_en) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ent[idx_r[AW-1:0]] <= {chan_r, a_r, b_nxt};
    end
    rd_ent_r <= mem_ent[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      tpc_pkg::S_IDLE: begin
        act_r <= in_action; chan_r <= in_channel_id; raw_r <= in_raw_value;
        r1_r <= in_point1_raw; c1_r <= in_point1_cal;
        hit_r <= 1'b0; rd_vld_r <= 1'b0; st_r <= tpc_pkg::ST_DONE;
        idx_r <= (in_action == tpc_pkg::ACT_APPEND) ? count_r : '0;
        bit_r <= 6'(NW - 1);
        rem_r <= '0;
        begin
          logic signed [32:0] dc, dr;
          dc = 33'(in_point2_cal) - 33'(in_point1_cal);
          dr = 33'(in_point2_raw) - 33'(in_point1_raw);
          neg_r <= dc[32] ^ dr[32];
          quo_r <= NW'(dc[32] ? -dc : dc) << FRAC_BITS;
          dvs_r <= (dc == 0 || dr == 0) ? '0 : NW'(dr[32] ? -dr : dr);
        end
        if (in_action == tpc_pkg::ACT_APPEND && count_r == CW'(TABLE_DEPTH))
          st_r <= tpc_pkg::ST_FULL;
      end
      tpc_pkg::S_DIV: begin
        bit_r <= bit_r - 1'b1;
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= NW'(rem_sh - {1'b0, dvs_r});
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[NW-1:0];
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
      end
      tpc_pkg::S_SLP: begin
        if (dvs_r == '0) begin
          a_r <= 32'(longint'(1) << FRAC_BITS); b_r <= '0; hit_r <= 1'b1;
        end else begin
          a_r <= tpc_pkg::sat32(66'(q_s));
        end
      end
      tpc_pkg::S_OFS: begin
        prod_r <= a_r * r1_r;
      end
      tpc_pkg::S_SCAN: begin
        rd_vld_r <= (idx_r != count_r);
        if (idx_r != count_r) idx_r <= idx_r + 1'b1;
        if (rd_vld_r && rd_chan == chan_r) begin
          hit_r <= 1'b1; a_r <= rd_slope; b_r <= rd_ofs;
        end
      end
      tpc_pkg::S_MUL: begin
        if (act_r == tpc_pkg::ACT_APPEND) begin
          b_r <= b_nxt;
          prod_r <= '0;
        end else begin
          prod_r <= a_r * raw_r;
        end
      end
      tpc_pkg::S_OUT: ;
      default: ;
    endcase
  end

  logic signed [31:0] mres;
  assign mres = tpc_pkg::sat32(fl + 66'(b_r));

  always_comb begin
    out_value_out = '0;
    out_status    = st_r;
    if (act_r == tpc_pkg::ACT_MEASURE) begin
      out_value_out = hit_r ? mres : raw_r;
      out_status    = hit_r ? tpc_pkg::ST_CAL : tpc_pkg::ST_PASS;
    end
    out_entries_used = 8'(count_r);
  end
endmodule

// ----- src/tpc_checker.sv -----
// Port checker for the two-point channel calibrator, bound to the top level
`timescale 1ns / 1ps
`include "two_point_channel_calibrator_defines.svh"
module tpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [1:0] in_action
);
  `TPC_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `TPC_ASSERT_IMP(a_out_busy, clk, rst_n, out_valid, busy)
  `TPC_ASSERT_NXT(a_out_release, clk, rst_n, out_valid, !busy && !out_valid)
  `TPC_ASSERT_NXT(a_clear_fast, clk, rst_n,
    start && !busy && in_action == tpc_pkg::ACT_CLEAR,
    out_valid && out_status == tpc_pkg::ST_DONE)
endmodule

bind two_point_channel_calibrator tpc_checker u_tpc_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status), .in_action(in_action)
);

// ----- tb/tb_two_point_channel_calibrator.sv -----
// Testbench: random and directed transfers through the channel calibration table
`timescale 1ns / 1ps
module tb_two_point_channel_calibrator;
  localparam int DEPTH = 128;
  localparam int FRAC  = 16;
  // action code with no function
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        chan;
    logic signed [31:0] raw;
    logic signed [31:0] r1;
    logic signed [31:0] c1;
    logic signed [31:0] r2;
    logic signed [31:0] c2;
  } cal_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [7:0]         used;
  } cal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [15:0] in_channel_id = '0;
  logic signed [31:0] in_raw_value = '0;
  logic signed [31:0] in_point1_raw = '0;
  logic signed [31:0] in_point1_cal = '0;
  logic signed [31:0] in_point2_raw = '0;
  logic signed [31:0] in_point2_cal = '0;
  logic out_valid;
  logic signed [31:0] out_value_out;
  logic [1:0] out_status;
  logic [7:0] out_entries_used;

  two_point_channel_calibrator u_top (.*);

  cal_item_t pending_items[$];
  cal_result_t expected_results[$];
  logic [15:0] tbl_chan[DEPTH];
  logic signed [31:0] tbl_slope[DEPTH];
  logic signed [31:0] tbl_offset[DEPTH];
  int tbl_count = 0;
  int fail_count = 0;
  bit calm = 1'b0;

  initial forever #1 clk = ~clk;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // arithmetic shift right is floor division by 2^FRAC
  function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
    return v >>> FRAC;
  endfunction

  function automatic cal_result_t calibrate(input cal_item_t it);
    cal_result_t res;
    logic signed [127:0] num, den, prod;
    logic signed [31:0] a, b;
    int hit;
    res = '0;
    case (it.action)
      tpc_pkg::ACT_CLEAR: tbl_count = 0;
      tpc_pkg::ACT_APPEND: begin
        if (tbl_count >= DEPTH) begin
          res.status = tpc_pkg::ST_FULL;
        end else begin
          if (it.r1 == it.r2 || it.c1 == it.c2) begin
            a = 32'sd1 <<< FRAC;
            b = 0;
          end else begin
            num = (128'(it.c2) - 128'(it.c1)) <<< FRAC;
            den = 128'(it.r2) - 128'(it.r1);
            a = clamp32(num / den);
            prod = 128'(a) * 128'(it.r1);
            b = clamp32(128'(it.c1) - floor_frac(prod));
          end
          tbl_chan[tbl_count] = it.chan;
          tbl_slope[tbl_count] = a;
          tbl_offset[tbl_count] = b;
          tbl_count++;
          res.status = tpc_pkg::ST_DONE;
        end
      end
      tpc_pkg::ACT_MEASURE: begin
        hit = -1;
        for (int k = 0; k < tbl_count; k++) if (tbl_chan[k] == it.chan) hit = k;
        if (hit >= 0) begin
          prod = 128'(tbl_slope[hit]) * 128'(it.raw);
          res.value = clamp32(floor_frac(prod) + 128'(tbl_offset[hit]));
          res.status = tpc_pkg::ST_CAL;
        end else begin
          res.value = it.raw;
          res.status = tpc_pkg::ST_PASS;
        end
      end
      default: ;
    endcase
    res.used = tbl_count[7:0];
    return res;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic cal_item_t mk(input logic [1:0] act, input logic [15:0] ch,
                                   input logic signed [31:0] raw, r1, c1, r2, c2);
    cal_item_t it;
    it.action = act; it.chan = ch; it.raw = raw;
    it.r1 = r1; it.c1 = c1; it.r2 = r2; it.c2 = c2;
    return it;
  endfunction

  task automatic drive_next();
    cal_item_t it;
    it = pending_items.pop_front();
    expected_results.push_back(calibrate(it));
    start <= 1'b1;
    in_action <= it.action;
    in_channel_id <= it.chan;
    in_raw_value <= it.raw;
    in_point1_raw <= it.r1;
    in_point1_cal <= it.c1;
    in_point2_raw <= it.r2;
    in_point2_cal <= it.c2;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 31))
          drive_next();
        else
          start <= 1'b0;
      end else if (!start && pending_items.size() > 0
                   && (calm || $urandom_range(0, 99) >= 31)) begin
        drive_next();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cal_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result value_out=%0d", out_value_out);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_value_out !== exp_r.value) begin
          $error("value_out expected %0d actual %0d", exp_r.value, out_value_out);
          fail_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_entries_used !== exp_r.used) begin
          $error("entries_used expected %0d actual %0d", exp_r.used, out_entries_used);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [15:0] ch;
    logic signed [31:0] r1;
    int n;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0000, 32'sh7fffffff, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h0001, 0, 0, 0,
                               32'sh00010000, 32'sh00020000));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h0002, 0, 32'sh00050000, 7,
                               32'sh00050000, 9));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h0003, 0, 1, 32'sh00030000,
                               5, 32'sh00030000));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'hffff, 0, 32'sh80000000,
                               32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h0004, 0, 0, 32'sh80000000,
                               1, 32'sh7fffffff));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h0005, 0, 32'sh7fffffff,
                               32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h0001, 0, 0, 32'sh00010000,
                               32'sh00010000, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0001, 32'sh00030000, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0004, 32'sh7fffffff, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0004, 32'sh80000000, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'hffff, 32'sh80000000, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0002, -5, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0009, 32'sh80000000, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_IGNORED, 16'hffff, -1, -1, -1, -1, -1));
    for (int i = 0; i < DEPTH - 5; i++)
      pending_items.push_back(mk(tpc_pkg::ACT_APPEND, i[15:0], 0, rand_q(), rand_q(),
                                 rand_q(), rand_q()));
    pending_items.push_back(mk(tpc_pkg::ACT_APPEND, 16'h00aa, 0, 0, 1, 2, 3));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0001, 32'sh00010000, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, 16'h0001, 32'sh00010000, 0, 0, 0, 0));

    // random: mostly small tables with a few channels, occasional clears
    n = 0;
    while (n < 1110) begin
      calm = (n >= 500 && n < 650);
      case ($urandom_range(0, 19))
        0: pending_items.push_back(mk(tpc_pkg::ACT_CLEAR, 16'($urandom()), rand_q(),
                                      rand_q(), rand_q(), rand_q(), rand_q()));
        1: pending_items.push_back(mk(ACT_IGNORED, 16'($urandom()), rand_q(), rand_q(),
                                      rand_q(), rand_q(), rand_q()));
        2, 3, 4, 5, 6, 7: begin
          ch = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
          r1 = rand_q();
          pending_items.push_back(mk(tpc_pkg::ACT_APPEND, ch, rand_q(), r1, rand_q(),
                                     ($urandom_range(0, 9) == 0) ? r1 : rand_q(), rand_q()));
        end
        default: begin
          ch = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 7));
          pending_items.push_back(mk(tpc_pkg::ACT_MEASURE, ch, rand_q(), rand_q(), rand_q(),
                                     rand_q(), rand_q()));
        end
      endcase
      n++;
      if (n % 100 == 0) wait (pending_items.size() < 20);
    end

    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("[two_point_channel_calibrator] OK");
    else
      $display("[two_point_channel_calibrator] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[two_point_channel_calibrator] ERROR");
    $finish;
  end
endmodule

// ----- two_point_channel_calibrator.f -----
+incdir+src
src/tpc_pkg.sv
src/two_point_channel_calibrator.sv
src/tpc_checker.sv
tb/tb_two_point_channel_calibrator.sv
